FILE: design/bhs_pkg.sv
// Package for the bucketed hash set engine: command and status codes,
// field widths and default sizes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bhs_pkg;

  localparam int NUM_BUCKETS_DEF  = 16;
  localparam int BUCKET_SLOTS_DEF = 8;

  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 3;
  localparam int BUCKET_W = 4;
  localparam int SLOT_W   = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;

endpackage
`default_nettype wire

FILE: design/bhs_if.sv
// Valid/ready channel interfaces for the bucketed hash set engine.
// Depends on bhs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface bhs_in_if;
  logic                        valid;
  logic                        ready;
  logic [bhs_pkg::CMD_W-1:0]   command;
  logic [bhs_pkg::KEY_W-1:0]   key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface bhs_out_if;
  logic                         valid;
  logic                         ready;
  logic [bhs_pkg::STATUS_W-1:0] status;
  logic [bhs_pkg::BUCKET_W-1:0] bucket;
  logic [bhs_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, output status, output bucket, output slot, input ready);
  modport sink   (input valid, input status, input bucket, input slot, output ready);
endinterface
`default_nettype wire

FILE: design/bucket_hash_set_engine.sv
// Top level of the bucketed hash set engine: front end, queue and bucket engine.
// Depends on bhs_pkg, bhs_if, bhs_front, bhs_queue and bhs_back.
//
// Each word carries a command (insert, delete, search; code 3 acts as search) and
// a 32-bit key, and yields one result word with status, bucket and slot. The front
// end computes key mod NUM_BUCKETS by a reciprocal multiplication, half by half,
// and hands the word on through a two-entry queue, so it works on the next key
// while the engine is busy. The engine takes one word at a time: it reads the
// bucket count, scans the occupied slots comparing each read entry with the key,
// then acts on the result; a delete then moves each later entry down one slot and
// lowers the count. The result waits in S_DONE until the output register is free.
// After reset the count memory is cleared one bucket per cycle, during which no
// word is accepted.
`timescale 1ns / 1ps
`default_nettype none
module bucket_hash_set_engine #(
  parameter int NUM_BUCKETS  = bhs_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_SLOTS = bhs_pkg::BUCKET_SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bhs_in_if.sink    in_ch,
  bhs_out_if.source out_ch
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int QW = bhs_pkg::CMD_W + bhs_pkg::KEY_W + BW;

  logic                      clearing;
  logic                      push_valid, push_ready;
  logic [bhs_pkg::CMD_W-1:0] push_cmd;
  logic [bhs_pkg::KEY_W-1:0] push_key;
  logic [BW-1:0]             push_bucket;
  logic                      pop_valid, pop_ready;
  logic [QW-1:0]             pop_data;

  bhs_front #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .hold        (clearing),
    .in_ch       (in_ch),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd),
    .push_key    (push_key),
    .push_bucket (push_bucket)
  );

  bhs_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_cmd, push_key, push_bucket}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  bhs_back #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_SLOTS (BUCKET_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .q_valid  (pop_valid),
    .q_ready  (pop_ready),
    .q_cmd    (pop_data[QW-1 -: bhs_pkg::CMD_W]),
    .q_key    (pop_data[BW +: bhs_pkg::KEY_W]),
    .q_bucket (pop_data[BW-1:0]),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

FILE: design/bhs_front.sv
// Front end: accepts a word and computes its bucket as key mod NUM_BUCKETS by
// multiplying the key with a fixed reciprocal, half by half. Uses bhs_pkg, bhs_if.
`timescale 1ns / 1ps
`default_nettype none
module bhs_front #(
  parameter int NUM_BUCKETS = bhs_pkg::NUM_BUCKETS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       hold,
  bhs_in_if.sink                          in_ch,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output logic [bhs_pkg::CMD_W-1:0]       push_cmd,
  output logic [bhs_pkg::KEY_W-1:0]       push_key,
  output logic [$clog2(NUM_BUCKETS)-1:0]  push_bucket
);

  localparam int KW = bhs_pkg::KEY_W;
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int SH = KW + BW;
  localparam int PW = KW + 33;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [15:0] RECIP_LO = RECIP[15:0];
  localparam logic [16:0] RECIP_HI = RECIP[32:16];
  localparam logic [KW-1:0] DIVISOR = KW'(NUM_BUCKETS);

  localparam logic [1:0] STEP_LO  = 2'd0;
  localparam logic [1:0] STEP_HI  = 2'd1;
  localparam logic [1:0] STEP_REM = 2'd2;

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [1:0]                      step_r, step_nxt;
  logic [bhs_pkg::CMD_W-1:0]       cmd_r, cmd_nxt;
  logic [KW-1:0]                   key_r, key_nxt;
  logic [PW-1:0]                   prod_r, prod_nxt;
  logic [BW-1:0]                   bkt_r, bkt_nxt;
  logic [KW+15:0]                  mul_lo;
  logic [KW+16:0]                  mul_hi;
  logic [KW-1:0]                   quo;

  assign in_ch.ready = !busy_r && !hold;
  assign push_valid  = done_r;
  assign push_cmd    = cmd_r;
  assign push_key    = key_r;
  assign push_bucket = bkt_r;

  assign mul_lo = {16'b0, key_r} * {{KW{1'b0}}, RECIP_LO};
  assign mul_hi = {17'b0, key_r} * {{KW{1'b0}}, RECIP_HI};
  assign quo    = KW'(prod_r[PW-1:SH]);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    step_nxt = step_r;
    cmd_nxt  = cmd_r;
    key_nxt  = key_r;
    prod_nxt = prod_r;
    bkt_nxt  = bkt_r;
    if (in_ch.valid && in_ch.ready) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      step_nxt = STEP_LO;
      cmd_nxt  = in_ch.command;
      key_nxt  = in_ch.key;
    end else if (busy_r && !done_r) begin
      step_nxt = step_r + 1'b1;
      case (step_r)
        STEP_LO: begin
          prod_nxt = {17'b0, mul_lo};
        end
        STEP_HI: begin
          prod_nxt = prod_r + {mul_hi, 16'b0};
        end
        STEP_REM: begin
          bkt_nxt  = key_r[BW-1:0] - BW'(quo * DIVISOR);
          done_nxt = 1'b1;
        end
        default: begin
          done_nxt = 1'b1;
        end
      endcase
    end else if (done_r && push_ready) begin
      done_nxt = 1'b0;
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    prod_r <= prod_nxt;
    bkt_r  <= bkt_nxt;
  end

endmodule
`default_nettype wire

FILE: design/bhs_queue.sv
// Two-entry queue that decouples the front end from the bucket engine.
// Generic payload width; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bhs_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] buf_r [2];
  logic             wp_r, wp_nxt;
  logic             rp_r, rp_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             do_wr, do_rd;

  assign wr_ready = fill_r != 2'd2;
  assign rd_valid = fill_r != 2'd0;
  assign rd_data  = buf_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wp_nxt   = do_wr ? !wp_r : wp_r;
    rp_nxt   = do_rd ? !rp_r : rp_r;
    fill_nxt = fill_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      buf_r[wp_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: design/bhs_back.sv
// Bucket engine: owns the key and count memories, scans a bucket one slot
// per cycle, appends, shifts on delete and drives the result register.
// Uses bhs_pkg and bhs_if.
`timescale 1ns / 1ps
`default_nettype none
module bhs_back #(
  parameter int NUM_BUCKETS  = bhs_pkg::NUM_BUCKETS_DEF,
  parameter int BUCKET_SLOTS = bhs_pkg::BUCKET_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  output logic                                clearing,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  wire logic [bhs_pkg::CMD_W-1:0]      q_cmd,
  input  wire logic [bhs_pkg::KEY_W-1:0]      q_key,
  input  wire logic [$clog2(NUM_BUCKETS)-1:0] q_bucket,
  bhs_out_if.source                           out_ch
);

  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int SW    = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int CW    = $clog2(BUCKET_SLOTS + 1);
  localparam int AW    = BW + SW;
  localparam int DEPTH = NUM_BUCKETS << SW;
  localparam logic [CW-1:0] SLOTS = CW'(BUCKET_SLOTS);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CNT   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_ACT   = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [bhs_pkg::KEY_W-1:0] ent_mem [DEPTH];
  logic [CW-1:0]             cnt_mem [NUM_BUCKETS];
  logic [bhs_pkg::KEY_W-1:0] ent_rd_r;
  logic [CW-1:0]             cnt_rd_r;

  logic                      ent_we;
  logic [AW-1:0]             ent_waddr, ent_raddr;
  logic [bhs_pkg::KEY_W-1:0] ent_wdata;
  logic                      cnt_we;
  logic [BW-1:0]             cnt_waddr;
  logic [CW-1:0]             cnt_wdata;

  logic [2:0]                   state_r, state_nxt;
  logic [BW-1:0]                clr_r, clr_nxt;
  logic [bhs_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [bhs_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [BW-1:0]                bkt_r, bkt_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;
  logic [CW-1:0]                pidx_r, pidx_nxt;
  logic [CW-1:0]                pos_r, pos_nxt;
  logic [CW-1:0]                wi_r, wi_nxt;
  logic                         pend_r, pend_nxt;
  logic                         hit_r, hit_nxt;
  logic [bhs_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [CW-1:0]                slot_r, slot_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [bhs_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [bhs_pkg::BUCKET_W-1:0] out_bucket_r, out_bucket_nxt;
  logic [bhs_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [BW+bhs_pkg::BUCKET_W-1:0] bkt_ext;
  logic [CW+bhs_pkg::SLOT_W-1:0]   slot_ext;

  assign clearing      = state_r == S_CLR;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.bucket = out_bucket_r;
  assign out_ch.slot   = out_slot_r;
  assign bkt_ext       = {{bhs_pkg::BUCKET_W{1'b0}}, bkt_r};
  assign slot_ext      = {{bhs_pkg::SLOT_W{1'b0}}, slot_r};

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    bkt_nxt        = bkt_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    pidx_nxt       = pidx_r;
    pos_nxt        = pos_r;
    wi_nxt         = wi_r;
    pend_nxt       = pend_r;
    hit_nxt        = hit_r;
    status_nxt     = status_r;
    slot_nxt       = slot_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_bucket_nxt = out_bucket_r;
    out_slot_nxt   = out_slot_r;
    q_ready        = 1'b0;
    ent_we         = 1'b0;
    ent_waddr      = {bkt_r, wi_r[SW-1:0]};
    ent_wdata      = ent_rd_r;
    ent_raddr      = {bkt_r, idx_r[SW-1:0]};
    cnt_we         = 1'b0;
    cnt_waddr      = bkt_r;
    cnt_wdata      = cnt_r;

    case (state_r)
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == BW'(NUM_BUCKETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cmd_nxt   = q_cmd;
          key_nxt   = q_key;
          bkt_nxt   = q_bucket;
          state_nxt = S_CNT;
        end
      end
      S_CNT: begin
        cnt_nxt   = cnt_rd_r;
        idx_nxt   = '0;
        pend_nxt  = 1'b0;
        hit_nxt   = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        pend_nxt = idx_r < cnt_r;
        pidx_nxt = idx_r;
        if (idx_r < cnt_r) begin
          idx_nxt = idx_r + 1'b1;
        end
        if (pend_r && ent_rd_r == key_r) begin
          hit_nxt   = 1'b1;
          pos_nxt   = pidx_r;
          state_nxt = S_ACT;
        end else if (!pend_r && idx_r >= cnt_r) begin
          state_nxt = S_ACT;
        end
      end
      S_ACT: begin
        slot_nxt  = '0;
        state_nxt = S_DONE;
        case (cmd_r)
          bhs_pkg::CMD_INSERT: begin
            if (hit_r) begin
              status_nxt = bhs_pkg::ST_DUPLICATE;
            end else if (cnt_r >= SLOTS) begin
              status_nxt = bhs_pkg::ST_FULL;
            end else begin
              ent_we     = 1'b1;
              ent_waddr  = {bkt_r, cnt_r[SW-1:0]};
              ent_wdata  = key_r;
              cnt_we     = 1'b1;
              cnt_wdata  = cnt_r + 1'b1;
              status_nxt = bhs_pkg::ST_INSERTED;
              slot_nxt   = cnt_r;
            end
          end
          bhs_pkg::CMD_DELETE: begin
            if (hit_r) begin
              status_nxt = bhs_pkg::ST_DELETED;
              slot_nxt   = pos_r;
              idx_nxt    = pos_r + 1'b1;
              pend_nxt   = 1'b0;
              state_nxt  = S_SHIFT;
            end else begin
              status_nxt = bhs_pkg::ST_ABSENT;
            end
          end
          default: begin
            if (hit_r) begin
              status_nxt = bhs_pkg::ST_FOUND;
              slot_nxt   = pos_r;
            end else begin
              status_nxt = bhs_pkg::ST_NOT_FOUND;
            end
          end
        endcase
      end
      S_SHIFT: begin
        if (idx_r < cnt_r) begin
          pend_nxt = 1'b1;
          wi_nxt   = idx_r - 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          ent_we = 1'b1;
        end
        if (!pend_r && idx_r >= cnt_r) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_bucket_nxt = bkt_ext[bhs_pkg::BUCKET_W-1:0];
          out_slot_nxt   = slot_ext[bhs_pkg::SLOT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    bkt_r        <= bkt_nxt;
    cnt_r        <= cnt_nxt;
    idx_r        <= idx_nxt;
    pidx_r       <= pidx_nxt;
    pos_r        <= pos_nxt;
    wi_r         <= wi_nxt;
    status_r     <= status_nxt;
    slot_r       <= slot_nxt;
    out_status_r <= out_status_nxt;
    out_bucket_r <= out_bucket_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_r <= ent_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[q_bucket];
  end

endmodule
`default_nettype wire
